@@ rtl/asid_pkg.sv @@
// Package with the shared types, constants and slot table of the ASID stream parser.
package asid_pkg;

    localparam logic [7:0] C_RT_MIN    = 8'hf8;
    localparam logic [7:0] C_SYX_START = 8'hf0;
    localparam logic [7:0] C_MFR_ID    = 8'h2d;
    localparam logic [7:0] C_CMD_START = 8'h4c;
    localparam logic [7:0] C_CMD_STOP  = 8'h4d;
    localparam logic [7:0] C_CMD_SEQ   = 8'h4e;
    localparam logic [7:0] C_CMD_LCD   = 8'h4f;
    localparam logic [4:0] C_NUM_SLOTS = 5'd28;
    localparam logic [3:0] C_IDX_DATA  = 4'd8;
    localparam logic [3:0] C_IDX_MSB   = 4'd4;

    localparam logic [1:0] C_ST_IGNORED  = 2'd0;
    localparam logic [1:0] C_ST_REJECTED = 2'd1;
    localparam logic [1:0] C_ST_CONSUMED = 2'd2;

    localparam logic C_OP_BYTE    = 1'b0;
    localparam logic C_OP_TIMEOUT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic scan_step;
        logic load_out;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } t_ctl_sts;

    function automatic logic [1:0] slot_grp(input logic [4:0] slot);
        logic [1:0] g;
        if (slot >= 5'd21) begin
            g = 2'd3;
        end else if (slot >= 5'd14) begin
            g = 2'd2;
        end else if (slot >= 5'd7) begin
            g = 2'd1;
        end else begin
            g = 2'd0;
        end
        return g;
    endfunction

    function automatic logic [2:0] slot_bit(input logic [4:0] slot);
        logic [4:0] r;
        r = slot - (5'(slot_grp(slot)) * 5'd7);
        return r[2:0];
    endfunction

    function automatic logic [4:0] slot_to_reg(input logic [4:0] slot);
        logic [4:0] a;
        case (slot)
            5'd0:  a = 5'h00;
            5'd1:  a = 5'h01;
            5'd2:  a = 5'h02;
            5'd3:  a = 5'h03;
            5'd4:  a = 5'h05;
            5'd5:  a = 5'h06;
            5'd6:  a = 5'h07;
            5'd7:  a = 5'h08;
            5'd8:  a = 5'h09;
            5'd9:  a = 5'h0a;
            5'd10: a = 5'h0c;
            5'd11: a = 5'h0d;
            5'd12: a = 5'h0e;
            5'd13: a = 5'h0f;
            5'd14: a = 5'h10;
            5'd15: a = 5'h11;
            5'd16: a = 5'h13;
            5'd17: a = 5'h14;
            5'd18: a = 5'h15;
            5'd19: a = 5'h16;
            5'd20: a = 5'h17;
            5'd21: a = 5'h18;
            5'd22: a = 5'h04;
            5'd23: a = 5'h0b;
            5'd24: a = 5'h12;
            5'd25: a = 5'h04;
            5'd26: a = 5'h0b;
            5'd27: a = 5'h12;
            default: a = 5'h00;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/asid_ctrl.sv @@
// Controller state machine that sequences capture, evaluation, slot scan and output.
module asid_ctrl import asid_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/asid_dp.sv @@
// Datapath holding the framing state, mask and MSB bytes, slot scan and output register.
module asid_dp import asid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl_cmd    i_cmd,
    output t_ctl_sts    o_sts,
    input  logic        i_opcode,
    input  logic [7:0]  i_port,
    input  logic [7:0]  i_midi_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_write_valid,
    output logic [4:0]  o_reg_addr,
    output logic [7:0]  o_reg_value,
    output logic        o_mode_on
);

    typedef enum logic [1:0] {
        F_WAIT_F0,
        F_WAIT_ID,
        F_CMD,
        F_DATA
    } t_frame;

    // Framing and stream state.
    t_frame      r_frame,  n_frame;
    logic        r_mode,   n_mode;
    logic [7:0]  r_owner,  n_owner;
    logic [7:0]  r_cmd,    n_cmd;
    logic [3:0]  r_stream, n_stream;
    logic [4:0]  r_slot,   n_slot;
    logic [6:0]  r_mask [4];
    logic [6:0]  r_msb  [4];

    // Captured input word.
    logic        r_op;
    logic [7:0]  r_port;
    logic [7:0]  r_byte;

    // Pending result.
    logic [1:0]  r_res_status, n_res_status;
    logic        r_res_wv,     n_res_wv;
    logic [4:0]  r_res_addr,   n_res_addr;
    logic [7:0]  r_res_val,    n_res_val;
    logic        r_res_mode,   n_res_mode;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic        r_out_wv;
    logic [4:0]  r_out_addr;
    logic [7:0]  r_out_val;
    logic        r_out_mode;

    logic        w_need_scan;
    logic        w_mask_we;
    logic        w_msb_we;
    logic [1:0]  w_grp;
    logic [2:0]  w_bit;
    logic        w_in_range;
    logic        w_hit;
    t_frame      w_frame_eff;

    assign w_grp      = slot_grp(r_slot);
    assign w_bit      = slot_bit(r_slot);
    assign w_in_range = (r_slot < C_NUM_SLOTS);
    assign w_hit      = w_in_range && r_mask[w_grp][w_bit];
    assign w_frame_eff = r_byte[7] ? F_WAIT_F0 : r_frame;

    always_comb begin
        n_frame      = r_frame;
        n_mode       = r_mode;
        n_owner      = r_owner;
        n_cmd        = r_cmd;
        n_stream     = r_stream;
        n_slot       = r_slot;
        n_res_status = r_res_status;
        n_res_wv     = r_res_wv;
        n_res_addr   = r_res_addr;
        n_res_val    = r_res_val;
        n_res_mode   = r_res_mode;
        w_need_scan  = 1'b0;
        w_mask_we    = 1'b0;
        w_msb_we     = 1'b0;

        if (i_cmd.eval) begin
            n_res_status = C_ST_IGNORED;
            n_res_wv     = 1'b0;
            n_res_addr   = '0;
            n_res_val    = '0;
            if (r_op == C_OP_TIMEOUT) begin
                if (r_frame != F_WAIT_F0 && r_port == r_owner) begin
                    n_frame = F_WAIT_F0;
                    n_owner = '0;
                    n_cmd   = '0;
                end
            end else if (r_byte >= C_RT_MIN) begin
                n_res_status = C_ST_IGNORED;
            end else if (r_mode && r_port != r_owner) begin
                n_res_status = C_ST_REJECTED;
            end else begin
                n_res_status = C_ST_CONSUMED;
                n_owner      = r_port;
                case (w_frame_eff)
                    F_WAIT_F0: begin
                        n_frame = (r_byte == C_SYX_START) ? F_WAIT_ID : F_WAIT_F0;
                    end
                    F_WAIT_ID: begin
                        n_frame = (r_byte == C_MFR_ID) ? F_CMD : F_WAIT_F0;
                    end
                    F_CMD: begin
                        n_cmd   = r_byte;
                        n_frame = F_DATA;
                        if (r_byte == C_CMD_START || r_byte == C_CMD_LCD) begin
                            n_mode = 1'b1;
                        end else if (r_byte == C_CMD_STOP) begin
                            n_mode = 1'b0;
                        end else if (r_byte == C_CMD_SEQ) begin
                            n_mode   = 1'b1;
                            n_stream = '0;
                            n_slot   = '0;
                        end
                    end
                    F_DATA: begin
                        if (r_cmd == C_CMD_SEQ) begin
                            if (r_stream < C_IDX_MSB) begin
                                w_mask_we = 1'b1;
                                n_stream  = r_stream + 4'd1;
                            end else if (r_stream < C_IDX_DATA) begin
                                w_msb_we = 1'b1;
                                n_stream = r_stream + 4'd1;
                            end else begin
                                w_need_scan = 1'b1;
                            end
                        end
                    end
                    default: n_frame = F_WAIT_F0;
                endcase
            end
            n_res_mode = n_mode;
        end

        // One slot is tested per cycle; the scan ends on a slot with its mask bit set or past the last one.
        if (i_cmd.scan_step && w_in_range) begin
            n_slot = r_slot + 5'd1;
            if (w_hit) begin
                n_res_wv   = 1'b1;
                n_res_addr = slot_to_reg(r_slot);
                n_res_val  = {r_msb[w_grp][w_bit], r_byte[6:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= F_WAIT_F0;
            r_mode      <= 1'b0;
            r_owner     <= '0;
            r_cmd       <= '0;
            r_stream    <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_frame  <= n_frame;
            r_mode   <= n_mode;
            r_owner  <= n_owner;
            r_cmd    <= n_cmd;
            r_stream <= n_stream;
            r_slot   <= n_slot;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_port <= i_port;
            r_byte <= i_midi_byte;
        end
        if (w_mask_we) begin
            r_mask[r_stream[1:0]] <= r_byte[6:0];
        end
        if (w_msb_we) begin
            r_msb[r_stream[1:0]] <= r_byte[6:0];
        end
        r_res_status <= n_res_status;
        r_res_wv     <= n_res_wv;
        r_res_addr   <= n_res_addr;
        r_res_val    <= n_res_val;
        r_res_mode   <= n_res_mode;
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_wv     <= r_res_wv;
            r_out_addr   <= r_res_addr;
            r_out_val    <= r_res_val;
            r_out_mode   <= r_res_mode;
        end
    end

    assign o_sts.need_scan = w_need_scan;
    assign o_sts.scan_done = !w_in_range || w_hit;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_write_valid = r_out_wv;
    assign o_reg_addr    = r_out_addr;
    assign o_reg_value   = r_out_val;
    assign o_mode_on     = r_out_mode;

endmodule

@@ rtl/asid_sysex_register_stream_parser_core.sv @@
// Top level of the ASID SysEx register stream parser: controller plus datapath.
//
//  Channel   Direction  Handshake            Payload
//  s_axis    in         tvalid / tready      tuser: opcode; tdata: port, midi_byte
//  m_axis    out        tvalid / tready      tuser: status, write_valid;
//                                            tdata: reg_addr, reg_value, mode_on
//
// Each input word is accepted (S_IDLE), evaluated (S_EVAL) and put in the output register
// once that is free (S_DONE); a sequence data byte adds the slot scan (S_SCAN) in between, one
// slot tested per cycle over the 28 slots, until an enabled slot or the end of the slots.
// One word is in work at a time; the next is taken once the current result sits in
// the output register, even while that result waits for m_axis_tready.
// Reset is synchronous and active low; the mask and MSB bytes are not reset.
module asid_sysex_register_stream_parser_core import asid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] port, [15:8] midi_byte
    input  logic        i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [4:0] reg_addr, [12:5] reg_value, [13] mode_on
    output logic [2:0]  o_m_axis_tuser    // [1:0] status, [2] write_valid
);

    t_ctl_cmd   w_cmd;
    t_ctl_sts   w_sts;
    logic [1:0] w_status;
    logic       w_wv;
    logic [4:0] w_addr;
    logic [7:0] w_val;
    logic       w_mode;

    asid_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    asid_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_s_axis_tuser),
        .i_port        (i_s_axis_tdata[7:0]),
        .i_midi_byte   (i_s_axis_tdata[15:8]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_status      (w_status),
        .o_write_valid (w_wv),
        .o_reg_addr    (w_addr),
        .o_reg_value   (w_val),
        .o_mode_on     (w_mode)
    );

    assign o_m_axis_tdata = {2'b00, w_mode, w_val, w_addr};
    assign o_m_axis_tuser = {w_wv, w_status};

endmodule

@@ dv/tb_asid_sysex_register_stream_parser_core.sv @@
// Self-checking testbench for the ASID SysEx register stream parser core.
module tb_asid_sysex_register_stream_parser_core;
    import asid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 40;

    // Register address for each of the 28 slots, slot 0 in the lowest bits.
    localparam logic [27:0][4:0] SLOT_REG = {
        5'h12, 5'h0b, 5'h04, 5'h12, 5'h0b, 5'h04, 5'h18, 5'h17, 5'h16, 5'h15,
        5'h14, 5'h13, 5'h11, 5'h10, 5'h0f, 5'h0e, 5'h0d, 5'h0c, 5'h0a, 5'h09,
        5'h08, 5'h07, 5'h06, 5'h05, 5'h03, 5'h02, 5'h01, 5'h00
    };

    typedef enum logic [1:0] {FRM_IDLE, FRM_ID, FRM_CMD, FRM_DATA} t_frame_phase;

    typedef struct packed {
        logic [1:0] status;
        logic       wr;
        logic [4:0] addr;
        logic [7:0] value;
        logic       mode;
    } t_parser_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;   // [7:0] port, [15:8] midi_byte
    logic        i_s_axis_tuser;   // [0] opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [4:0] reg_addr, [12:5] reg_value, [13] mode_on
    logic [2:0]  o_m_axis_tuser;   // [1:0] status, [2] write_valid

    // Shadow copy of the parser state.
    t_frame_phase frm;
    logic         asid_on;
    logic [7:0]   owner;
    logic [7:0]   cmd;
    logic [3:0]   stream_idx;
    logic [4:0]   slot_idx;
    logic [6:0]   mask_q [4];
    logic [6:0]   msb_q [4];

    t_parser_reply replies_q [$];
    t_parser_reply got_reply;

    int  fail_count;
    int  words_sent;
    int  writes_seen;
    int  rejects_seen;
    int  others_seen;
    int  cycle_count;
    int  stall_left;
    bit  tx_idling;
    bit  rx_idling;
    bit  long_hold_req;

    asid_sysex_register_stream_parser_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic clear_parser_state;
        frm        = FRM_IDLE;
        asid_on    = 1'b0;
        owner      = 8'h00;
        cmd        = 8'h00;
        stream_idx = 4'd0;
        slot_idx   = 5'd0;
        for (int i = 0; i < 4; i++) begin
            mask_q[i] = 7'h00;
            msb_q[i]  = 7'h00;
        end
    endtask

    function automatic t_parser_reply parse_midi_word(input logic op, input logic [7:0] port,
                                                      input logic [7:0] b);
        t_parser_reply r;
        bit            hit;
        int            grp;
        int            pos;
        int            s;
        r   = '0;
        hit = 1'b0;
        if (op == C_OP_TIMEOUT) begin
            if (frm != FRM_IDLE && port == owner) begin
                frm   = FRM_IDLE;
                owner = 8'h00;
                cmd   = 8'h00;
            end
            r.status = C_ST_IGNORED;
        end else if (b >= C_RT_MIN) begin
            r.status = C_ST_IGNORED;
        end else if (asid_on && port != owner) begin
            r.status = C_ST_REJECTED;
        end else begin
            r.status = C_ST_CONSUMED;
            owner    = port;
            if (b[7]) begin
                frm = FRM_IDLE;
            end
            case (frm)
                FRM_IDLE: begin
                    if (b == C_SYX_START) frm = FRM_ID;
                end
                FRM_ID: begin
                    frm = (b == C_MFR_ID) ? FRM_CMD : FRM_IDLE;
                end
                FRM_CMD: begin
                    cmd = b;
                    case (b)
                        C_CMD_START: asid_on = 1'b1;
                        C_CMD_STOP:  asid_on = 1'b0;
                        C_CMD_SEQ: begin
                            asid_on    = 1'b1;
                            stream_idx = 4'd0;
                            slot_idx   = 5'd0;
                        end
                        C_CMD_LCD:   asid_on = 1'b1;
                        default: ;
                    endcase
                    frm = FRM_DATA;
                end
                default: begin
                    if (cmd == C_CMD_SEQ) begin
                        if (stream_idx < C_IDX_MSB) begin
                            mask_q[stream_idx[1:0]] = b[6:0];
                            stream_idx++;
                        end else if (stream_idx < C_IDX_DATA) begin
                            msb_q[stream_idx[1:0]] = b[6:0];
                            stream_idx++;
                        end else begin
                            // Walk forward to the next enabled slot; it stays at 28 once used up.
                            while (!hit && slot_idx < C_NUM_SLOTS) begin
                                grp = int'(slot_idx) / 7;
                                pos = int'(slot_idx) % 7;
                                s   = int'(slot_idx);
                                slot_idx++;
                                if (mask_q[grp][pos]) begin
                                    hit     = 1'b1;
                                    r.wr    = 1'b1;
                                    r.addr  = SLOT_REG[s];
                                    r.value = {msb_q[grp][pos], b[6:0]};
                                end
                            end
                        end
                    end
                end
            endcase
        end
        r.mode = asid_on;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            replies_q.push_back(parse_midi_word(i_s_axis_tuser, i_s_axis_tdata[7:0],
                                                i_s_axis_tdata[15:8]));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (replies_q.size() == 0) begin
                $error("output word with nothing outstanding: tuser=%h tdata=%h",
                       o_m_axis_tuser, o_m_axis_tdata);
                fail_count++;
            end else begin
                got_reply = replies_q.pop_front();
                if (o_m_axis_tuser[1:0] !== got_reply.status) begin
                    $error("status: expected %0d, actual %0d", got_reply.status,
                           o_m_axis_tuser[1:0]);
                    fail_count++;
                end
                if (o_m_axis_tuser[2] !== got_reply.wr) begin
                    $error("write_valid: expected %0d, actual %0d", got_reply.wr,
                           o_m_axis_tuser[2]);
                    fail_count++;
                end
                if (o_m_axis_tdata[4:0] !== got_reply.addr) begin
                    $error("reg_addr: expected %h, actual %h", got_reply.addr,
                           o_m_axis_tdata[4:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[12:5] !== got_reply.value) begin
                    $error("reg_value: expected %h, actual %h", got_reply.value,
                           o_m_axis_tdata[12:5]);
                    fail_count++;
                end
                if (o_m_axis_tdata[13] !== got_reply.mode) begin
                    $error("mode_on: expected %0d, actual %0d", got_reply.mode,
                           o_m_axis_tdata[13]);
                    fail_count++;
                end
                if (o_m_axis_tdata[15:14] !== 2'b00) begin
                    $error("tdata padding: expected 0, actual %0d", o_m_axis_tdata[15:14]);
                    fail_count++;
                end
                if (got_reply.wr) begin
                    writes_seen++;
                end else if (got_reply.status == C_ST_REJECTED) begin
                    rejects_seen++;
                end else begin
                    others_seen++;
                end
            end
        end
    end

    // Output side: random short stalls, plus one long hold on request.
    initial begin
        i_m_axis_tready = 1'b0;
        stall_left      = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && rx_idling && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_word(input logic op, input logic [7:0] port, input logic [7:0] mbyte);
        if (tx_idling && $urandom_range(0, 4) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {mbyte, port};
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_byte(input logic [7:0] port, input logic [7:0] mbyte);
        send_word(C_OP_BYTE, port, mbyte);
    endtask

    task automatic send_header(input logic [7:0] port, input logic [7:0] command);
        send_byte(port, C_SYX_START);
        send_byte(port, C_MFR_ID);
        send_byte(port, command);
    endtask

    task automatic drain_replies;
        i_s_axis_tvalid <= 1'b0;
        while (replies_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_port;
        logic [7:0] p;
        if (asid_on && $urandom_range(0, 9) != 0) begin
            p = owner;
        end else begin
            case ($urandom_range(0, 5))
                0:       p = 8'h00;
                1:       p = 8'h01;
                2:       p = 8'h02;
                3:       p = 8'h80;
                4:       p = 8'hff;
                default: p = 8'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    task automatic send_sequence(input logic [7:0] port);
        int n;
        send_header(port, C_CMD_SEQ);
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 3))
                0:       send_byte(port, 8'h7f);
                1:       send_byte(port, 8'h00);
                default: send_byte(port, 8'($urandom_range(0, 127)));
            endcase
        end
        for (int i = 0; i < 4; i++) begin
            send_byte(port, 8'($urandom_range(0, 127)));
        end
        n = $urandom_range(0, 32);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(C_RT_MIN, 255)));
            end
            if ($urandom_range(0, 24) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)));
            end
            send_byte(port, 8'($urandom_range(0, 127)));
        end
        case ($urandom_range(0, 3))
            0:       send_byte(port, 8'hf7);
            1:       send_word(C_OP_TIMEOUT, port, 8'($urandom_range(0, 255)));
            2:       send_word(C_OP_TIMEOUT, 8'($urandom_range(0, 255)), 8'h00);
            default: ;
        endcase
    endtask

    task automatic send_command(input logic [7:0] port);
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = C_CMD_START;
            1:       c = C_CMD_STOP;
            2:       c = C_CMD_LCD;
            default: c = 8'($urandom_range(0, 127));
        endcase
        send_header(port, c);
        repeat ($urandom_range(0, 4)) send_byte(port, 8'($urandom_range(0, 127)));
    endtask

    task automatic send_broken(input logic [7:0] port);
        case ($urandom_range(0, 3))
            0: begin
                send_byte(port, C_SYX_START);
                send_byte(port, 8'($urandom_range(0, 255)));
            end
            1: begin
                send_byte(port, C_SYX_START);
                send_byte(port, C_MFR_ID);
                send_byte(port, 8'($urandom_range(8'h80, 8'hf7)));
            end
            2: begin
                send_header(port, C_CMD_SEQ);
                repeat ($urandom_range(0, 7)) send_byte(port, 8'($urandom_range(0, 127)));
                send_byte(port, C_SYX_START);
            end
            default: begin
                send_header(port, C_CMD_SEQ);
                repeat ($urandom_range(0, 12)) send_byte(port, 8'($urandom_range(0, 127)));
                send_word(C_OP_TIMEOUT, port, 8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Wrong manufacturer ID, and a timeout that finds framing already idle.
    task automatic test_framing_basics;
        send_byte(8'hff, C_SYX_START);
        send_byte(8'hff, 8'h00);
        send_word(C_OP_TIMEOUT, 8'hff, 8'hff);
        drain_replies();
    endtask

    // Sparse masks reach slots 0 and 27, then slots run out; a reject and realtime byte follow.
    task automatic test_sequence_slots;
        send_header(8'hff, C_CMD_SEQ);
        send_byte(8'hff, 8'h01);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, 8'h40);
        send_byte(8'hff, 8'h01);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, 8'h7f);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, 8'h33);
        send_byte(8'h00, 8'h10);
        send_byte(8'h03, 8'hff);
        drain_replies();
    endtask

    // Stop, LCD, a timeout from the owner, then an unknown command on port 0.
    task automatic test_mode_commands;
        send_header(8'hff, C_CMD_STOP);
        send_header(8'hff, C_CMD_LCD);
        send_word(C_OP_TIMEOUT, 8'hff, 8'h00);
        send_byte(8'hff, 8'h22);
        send_header(8'h00, 8'h01);
        send_byte(8'h00, 8'h55);
        send_byte(8'h00, 8'hf7);
        drain_replies();
    endtask

    // The output side holds off for a long stretch while a full sequence is offered.
    task automatic test_output_backpressure;
        logic [7:0] p;
        tx_idling     = 1'b0;
        long_hold_req = 1'b1;
        p             = pick_port();
        send_header(p, C_CMD_SEQ);
        repeat (4) send_byte(p, 8'h7f);
        repeat (4) send_byte(p, 8'($urandom_range(0, 127)));
        repeat (12) send_byte(p, 8'($urandom_range(0, 127)));
        drain_replies();
        tx_idling = 1'b1;
    endtask

    task automatic test_random_traffic(input int until_words);
        int pick;
        while (words_sent < until_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_sequence(pick_port());
            end else if (pick < 70) begin
                send_command(pick_port());
            end else if (pick < 85) begin
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            end else begin
                send_broken(pick_port());
            end
        end
        drain_replies();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 16'h0000;
        i_s_axis_tuser  = 1'b0;
        fail_count      = 0;
        words_sent      = 0;
        writes_seen     = 0;
        rejects_seen    = 0;
        others_seen     = 0;
        tx_idling       = 1'b1;
        rx_idling       = 1'b1;
        long_hold_req   = 1'b0;
        clear_parser_state();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_framing_basics();
        test_sequence_slots();
        test_mode_commands();
        test_output_backpressure();
        test_random_traffic(1060);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        test_random_traffic(1230);

        repeat (DRAIN_WAIT) @(negedge i_clk);
        $display("Ran %0d input words (framing, commands, sequences, timeouts, noise).",
                 words_sent);
        $display("Checked %0d register writes, %0d foreign-port rejects, %0d other words.",
                 writes_seen, rejects_seen, others_seen);
        if (fail_count == 0 && replies_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (replies_q.size() != 0) begin
                $error("%0d output words never arrived", replies_q.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/asid_pkg.sv
rtl/asid_ctrl.sv
rtl/asid_dp.sv
rtl/asid_sysex_register_stream_parser_core.sv
dv/tb_asid_sysex_register_stream_parser_core.sv
